### hdl/ryuv_pkg.sv
// Shared constants, types and the sRGB encode table function for the RGB to
// 4:2:0 YCbCr converter. No dependencies.
package ryuv_pkg;

   localparam int MAX_WIDTH        = 4096;
   localparam int MAX_HEIGHT       = 4096;
   localparam int GAMMA_TABLE_SIZE = 4096;
   localparam int FRACTION_BITS    = 12;
   localparam int WORK_BITS        = 18;

   localparam int COMP_W    = FRACTION_BITS + 1;   // clamped component, 0..1.0
   localparam int PAIR_W    = COMP_W + 1;          // sum of two components
   localparam int QUAD_W    = COMP_W + 2;          // sum of four components
   localparam int WORK_W    = WORK_BITS + 1;       // Q18 value, 0..1.0
   localparam int LINE_DEPTH = MAX_WIDTH / 2;
   localparam int LINE_AW   = $clog2(LINE_DEPTH);
   localparam int LINE_W    = 3 * PAIR_W;
   localparam int GAMMA_AW  = $clog2(GAMMA_TABLE_SIZE);
   localparam int IDX_PROD_W = QUAD_W + GAMMA_AW + 1;
   localparam int COUNT_W   = 12;
   localparam int CFG_W     = 13;
   localparam int CSR_IDX_W = 2;
   localparam int ACC_W     = 43;
   localparam int COEF_W    = 23;
   localparam int M_W       = 22;
   localparam int RECIP_W   = 23;
   localparam int RECIP_SHIFT = 36;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAMMA_ENABLE = 2'd2;

   localparam logic [CFG_W-1:0] RESET_WIDTH  = 13'd1920;
   localparam logic [CFG_W-1:0] RESET_HEIGHT = 13'd1080;

   // Matrix coefficients (units of 1/10000) with the output scale folded in.
   localparam logic signed [COEF_W-1:0] CY_R = 23'sd465594;    // 2126 * 219
   localparam logic signed [COEF_W-1:0] CY_G = 23'sd1566288;   // 7152 * 219
   localparam logic signed [COEF_W-1:0] CY_B = 23'sd158118;    // 722 * 219
   localparam logic signed [COEF_W-1:0] CU_R = -23'sd256704;
   localparam logic signed [COEF_W-1:0] CU_G = -23'sd863296;
   localparam logic signed [COEF_W-1:0] CU_B = 23'sd1120000;
   localparam logic signed [COEF_W-1:0] CV_R = 23'sd1120000;
   localparam logic signed [COEF_W-1:0] CV_G = -23'sd1017408;
   localparam logic signed [COEF_W-1:0] CV_B = -23'sd102592;

   localparam logic signed [ACC_W-1:0] LUMA_ADD   = 43'sd170000;   // 17 * 10000
   localparam logic signed [ACC_W-1:0] CHROMA_ADD = 43'sd1290000;  // 129 * 10000
   localparam logic signed [ACC_W-1:0] BYTE_LIMIT = 43'sd2560000;  // 256 * 10000
   localparam logic [M_W-1:0]          M_MAX      = 22'd2559999;
   // ceil(2^36 / 10000): exact floor division for values below 2^22
   localparam logic [RECIP_W-1:0]      RECIP_10K  = 23'd6871948;

   typedef struct packed {
      logic       accept;
      logic       issue;
      logic [2:0] issue_sel;
      logic       mac;
      logic       norm;
      logic       recip;
      logic       load_out;
   } ctrl_cmd_type;

   typedef struct packed {
      logic out_free;
   } ctrl_status_type;

   localparam longint unsigned GammaDen    = GAMMA_TABLE_SIZE - 1;
   localparam longint unsigned GammaLinDen = 100 * GammaDen;
   localparam longint unsigned Q30One      = 64'd1 << 30;

   function automatic logic [COMP_W-1:0] clamp_comp(input logic signed [15:0] v);
      logic signed [16:0] one;
      one = 17'sd1 <<< FRACTION_BITS;
      if (v < 0)
         return '0;
      else if ({v[15], v} > one)
         return one[COMP_W-1:0];
      else
         return v[COMP_W-1:0];
   endfunction

   function automatic longint unsigned qmul(input longint unsigned a, input longint unsigned b);
      return (a * b) >> 30;
   endfunction

   function automatic longint unsigned cube_root_q30(input longint unsigned x);
      longint unsigned y;
      longint unsigned t;
      y = 0;
      for (int b = 30; b >= 0; b--) begin
         t = y | (64'd1 << b);
         if (t <= Q30One) begin
            if (qmul(qmul(t, t), t) <= x)
               y = t;
         end
      end
      return y;
   endfunction

   function automatic longint unsigned isqrt64(input longint unsigned n);
      longint unsigned y;
      longint unsigned t;
      y = 0;
      for (int b = 30; b >= 0; b--) begin
         t = y | (64'd1 << b);
         if (t * t <= n)
            y = t;
      end
      return y;
   endfunction

   // sRGB encode of i/(GAMMA_TABLE_SIZE-1) in Q18; evaluated at elaboration
   function automatic logic [WORK_W-1:0] gamma_entry(input int unsigned idx);
      longint unsigned i;
      longint unsigned q18;
      longint unsigned x;
      longint unsigned t;
      longint unsigned t2;
      longint unsigned t5;
      longint unsigned s;
      i = idx;
      if (i * 64'd10000000 <= 64'd31308 * GammaDen) begin
         q18 = (i * 64'd1292 * (64'd1 << WORK_BITS) + GammaLinDen / 2) / GammaLinDen;
      end else begin
         x  = (i * Q30One + GammaDen / 2) / GammaDen;
         t  = isqrt64(isqrt64(cube_root_q30(x) << 30) << 30);
         t2 = qmul(t, t);
         t5 = qmul(qmul(t2, t2), t);
         s  = (t5 * 64'd1055 + 64'd500) / 64'd1000;
         s  = (s < 64'd59055800) ? 64'd0 : s - 64'd59055800;
         if (s > Q30One)
            s = Q30One;
         q18 = (s + 64'd2048) >> 12;
      end
      if (q18 > (64'd1 << WORK_BITS))
         q18 = 64'd1 << WORK_BITS;
      return q18[WORK_W-1:0];
   endfunction

endpackage

### hdl/rgb_to_yuv420_converter_unit.sv
// Top level of the BT.709 RGB to 4:2:0 YCbCr converter (limited range).
// Depends on ryuv_pkg, ryuv_ctrl and ryuv_datapath.
//
//   channel  direction  handshake          payload
//   req_     in         req_valid/stall    red, green, blue (signed Q4.12)
//   rsp_     out        rsp_valid/stall    luma, chroma_valid, u/v_value, frame_end
//   csr_     in         csr_valid/ready    csr_index, csr_data
//
// One pixel at a time: accept, six lookups through the single read port
// of the sRGB table (three for luma, three for the block average), normalize
// and divide, then load of the output register; req_stall holds off the next pixel till then.
// Reset is synchronous; the line buffer needs no clearing pass.
// A stalled result sits in the output register while the next pixel is worked.
module rgb_to_yuv420_converter_unit
   import ryuv_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_data,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic signed [15:0]   req_red,
   input  logic signed [15:0]   req_green,
   input  logic signed [15:0]   req_blue,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [7:0]           rsp_luma,
   output logic                 rsp_chroma_valid,
   output logic [7:0]           rsp_u_value,
   output logic [7:0]           rsp_v_value,
   output logic                 rsp_frame_end
);

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   ryuv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   ryuv_datapath u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_red          (req_red),
      .req_green        (req_green),
      .req_blue         (req_blue),
      .cmd              (cmd),
      .rsp_luma         (rsp_luma),
      .rsp_chroma_valid (rsp_chroma_valid),
      .rsp_u_value      (rsp_u_value),
      .rsp_v_value      (rsp_v_value),
      .rsp_frame_end    (rsp_frame_end)
   );

endmodule

### hdl/ryuv_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ryuv_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en)
         mem_ff[wr_addr] <= wr_data;
      if (rd_en)
         rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/ryuv_gamma_rom.sv
// sRGB encode table as a constant ROM with registered read.
// Depends on ryuv_pkg (table size and entry function).
module ryuv_gamma_rom
   import ryuv_pkg::*;
(
   input  logic                clock,
   input  logic [GAMMA_AW-1:0] rd_addr,
   output logic [WORK_W-1:0]   rd_data
);

   logic [WORK_W-1:0] tab [GAMMA_TABLE_SIZE];
   logic [WORK_W-1:0] rd_data_ff;

   for (genvar gi = 0; gi < GAMMA_TABLE_SIZE; gi++) begin : g_tab
      localparam logic [WORK_W-1:0] Entry = gamma_entry(gi);
      assign tab[gi] = Entry;
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= tab[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/ryuv_ctrl.sv
// Sequencer for the converter: accept, six table lookups with MAC, normalize,
// divide, deliver. Depends on ryuv_pkg (command and status structs).
module ryuv_ctrl
   import ryuv_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output ctrl_cmd_type    cmd,
   output ctrl_status_type status
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_FETCH = 3'd1;
   localparam logic [2:0] ST_NORM  = 3'd2;
   localparam logic [2:0] ST_RECIP = 3'd3;
   localparam logic [2:0] ST_OUT   = 3'd4;
   localparam logic [2:0] LAST_STEP = 3'd6;

   logic [2:0] state_ff, state_in;
   logic [2:0] cnt_ff, cnt_in;
   logic       rsp_valid_ff, rsp_valid_in;

   assign status.out_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      cmd.issue_sel = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               cnt_in     = '0;
               state_in   = ST_FETCH;
            end
         end
         ST_FETCH: begin
            cmd.issue = (cnt_ff != LAST_STEP);
            cmd.mac   = (cnt_ff != 3'd0);
            cnt_in    = cnt_ff + 3'd1;
            if (cnt_ff == LAST_STEP)
               state_in = ST_NORM;
         end
         ST_NORM: begin
            cmd.norm = 1'b1;
            state_in = ST_RECIP;
         end
         ST_RECIP: begin
            cmd.recip = 1'b1;
            state_in  = ST_OUT;
         end
         ST_OUT: begin
            // hold the result until the output register frees up
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_accept_starts_fetch: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_FETCH) && (cnt_ff == 3'd0))
      else $error("accepted request did not start the lookup sequence");

   a_result_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("response raised outside the delivery state");

   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FETCH) |-> (cnt_ff <= LAST_STEP))
      else $error("lookup step counter out of range");

   a_stalled_out_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && rsp_valid_ff && rsp_stall) |=> (state_ff == ST_OUT))
      else $error("result left while the output was still stalled");

endmodule

### hdl/ryuv_datapath.sv
// Datapath: config registers, raster counters, line buffer, gamma lookup,
// color matrix MAC, byte rounding and the output register.
// Depends on ryuv_pkg, ryuv_ram and ryuv_gamma_rom.
module ryuv_datapath
   import ryuv_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_data,
   input  logic signed [15:0]   req_red,
   input  logic signed [15:0]   req_green,
   input  logic signed [15:0]   req_blue,
   input  ctrl_cmd_type         cmd,
   output logic [7:0]           rsp_luma,
   output logic                 rsp_chroma_valid,
   output logic [7:0]           rsp_u_value,
   output logic [7:0]           rsp_v_value,
   output logic                 rsp_frame_end
);

   logic [CFG_W-1:0]   width_ff, height_ff;
   logic               gamma_ff;
   logic [COUNT_W-1:0] col_ff, row_ff;
   logic [COMP_W-1:0]  px_ff [3];
   logic [COMP_W-1:0]  hold_ff [3];
   logic [PAIR_W-1:0]  pair_ff [3];
   logic               chroma_ff, frame_end_ff;
   logic [2:0]         k_ff;
   logic [WORK_W-1:0]  raw_ff, raw_in;
   logic signed [ACC_W-1:0] acc_ff [3];
   logic [M_W-1:0]     m_ff [3];
   logic [7:0]         q_ff [3];
   logic [7:0]         luma_ff, u_ff, v_ff;
   logic               cv_ff, fe_ff;

   logic [COMP_W-1:0]  px_in [3];
   logic [PAIR_W-1:0]  pair_in [3];
   logic [LINE_W-1:0]  line_wr, line_rd;
   logic [CFG_W-1:0]   w_eff, h_eff, col_next, row_next;
   logic               last_col, last_row, line_wr_en, in_line;
   logic [LINE_AW-1:0] line_addr;
   logic [GAMMA_AW-1:0] rom_addr;
   logic [WORK_W-1:0]  rom_q, work;
   logic [QUAD_W-1:0]  quad;
   logic [IDX_PROD_W-1:0] idx_prod;
   logic [1:0]         ci;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RESET_WIDTH;
         height_ff <= RESET_HEIGHT;
         gamma_ff  <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_FRAME_WIDTH:  width_ff  <= csr_data;
            CSR_FRAME_HEIGHT: height_ff <= csr_data;
            CSR_GAMMA_ENABLE: gamma_ff  <= csr_data[0];
            default: ;
         endcase
      end
   end

   // raster position
   always_comb begin
      w_eff = width_ff;
      if (width_ff == '0)
         w_eff = 13'd1;
      else if (width_ff > CFG_W'(MAX_WIDTH))
         w_eff = CFG_W'(MAX_WIDTH);
      h_eff = height_ff;
      if (height_ff == '0)
         h_eff = 13'd1;
      else if (height_ff > CFG_W'(MAX_HEIGHT))
         h_eff = CFG_W'(MAX_HEIGHT);
      col_next = {1'b0, col_ff} + 13'd1;
      row_next = {1'b0, row_ff} + 13'd1;
      last_col = (col_next >= w_eff);
      last_row = (row_next >= h_eff);
      in_line  = ({1'b0, col_ff} >> 1) < CFG_W'(LINE_DEPTH);
   end

   assign px_in[0] = clamp_comp(req_red);
   assign px_in[1] = clamp_comp(req_green);
   assign px_in[2] = clamp_comp(req_blue);

   for (genvar gc = 0; gc < 3; gc++) begin : g_pair
      assign pair_in[gc] = {1'b0, hold_ff[gc]} + {1'b0, px_in[gc]};
      assign line_wr[gc*PAIR_W +: PAIR_W] = pair_in[gc];
   end

   assign line_addr  = col_ff[LINE_AW:1];
   assign line_wr_en = cmd.accept && col_ff[0] && !row_ff[0] && in_line;

   ryuv_ram #(.WIDTH(LINE_W), .DEPTH(LINE_DEPTH)) u_line (
      .clock   (clock),
      .wr_en   (line_wr_en),
      .wr_addr (line_addr),
      .wr_data (line_wr),
      .rd_en   (cmd.accept),
      .rd_addr (line_addr),
      .rd_data (line_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         for (int i = 0; i < 3; i++)
            hold_ff[i] <= '0;
      end else if (cmd.accept) begin
         if (!col_ff[0]) begin
            for (int i = 0; i < 3; i++)
               hold_ff[i] <= px_in[i];
         end
         if (last_col) begin
            col_ff <= '0;
            row_ff <= last_row ? '0 : row_next[COUNT_W-1:0];
         end else begin
            col_ff <= col_next[COUNT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         for (int i = 0; i < 3; i++) begin
            px_ff[i]   <= px_in[i];
            pair_ff[i] <= pair_in[i];
         end
         chroma_ff    <= col_ff[0] && row_ff[0] && in_line;
         frame_end_ff <= last_col && last_row;
      end
   end

   // lookup address and linear value for step k: pixel for luma, 2x2 sum for chroma
   always_comb begin
      ci   = (cmd.issue_sel >= 3'd6) ? 2'd0 :
             (cmd.issue_sel >= 3'd3) ? 2'(cmd.issue_sel - 3'd3) : 2'(cmd.issue_sel);
      quad = {1'b0, line_rd[ci*PAIR_W +: PAIR_W]} + {1'b0, pair_ff[ci]};
      if (cmd.issue_sel < 3'd3) begin
         idx_prod = (IDX_PROD_W'(px_ff[ci]) * IDX_PROD_W'(GammaDen)
                     + (IDX_PROD_W'(1) << (FRACTION_BITS - 1))) >> FRACTION_BITS;
         raw_in   = WORK_W'(px_ff[ci]) << (WORK_BITS - FRACTION_BITS);
      end else begin
         idx_prod = (IDX_PROD_W'(quad) * IDX_PROD_W'(GammaDen)
                     + (IDX_PROD_W'(1) << (FRACTION_BITS + 1))) >> (FRACTION_BITS + 2);
         raw_in   = WORK_W'(quad) << (WORK_BITS - FRACTION_BITS - 2);
      end
      if (idx_prod > IDX_PROD_W'(GammaDen))
         rom_addr = GAMMA_AW'(GammaDen);
      else
         rom_addr = idx_prod[GAMMA_AW-1:0];
   end

   ryuv_gamma_rom u_gamma (
      .clock   (clock),
      .rd_addr (rom_addr),
      .rd_data (rom_q)
   );

   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         raw_ff <= raw_in;
         k_ff   <= cmd.issue_sel;
      end
   end

   assign work = gamma_ff ? rom_q : raw_ff;

   function automatic logic signed [COEF_W-1:0] coef(input logic [1:0] o, input logic [2:0] k);
      logic signed [COEF_W-1:0] c;
      c = '0;
      case ({o, k})
         {2'd0, 3'd0}: c = CY_R;
         {2'd0, 3'd1}: c = CY_G;
         {2'd0, 3'd2}: c = CY_B;
         {2'd1, 3'd3}: c = CU_R;
         {2'd1, 3'd4}: c = CU_G;
         {2'd1, 3'd5}: c = CU_B;
         {2'd2, 3'd3}: c = CV_R;
         {2'd2, 3'd4}: c = CV_G;
         {2'd2, 3'd5}: c = CV_B;
         default: c = '0;
      endcase
      return c;
   endfunction

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         for (int i = 0; i < 3; i++)
            acc_ff[i] <= '0;
      end else if (cmd.mac) begin
         for (int i = 0; i < 3; i++)
            acc_ff[i] <= acc_ff[i]
               + ACC_W'(coef(2'(i), k_ff) * $signed({1'b0, work}));
      end
   end

   // floor(acc / 2^18) plus offset, clipped to the byte range times 10000
   always_ff @(posedge clock) begin
      if (cmd.norm) begin
         for (int i = 0; i < 3; i++) begin
            logic signed [ACC_W-1:0] t;
            t = (acc_ff[i] >>> WORK_BITS) + ((i == 0) ? LUMA_ADD : CHROMA_ADD);
            if (t < 0)
               m_ff[i] <= '0;
            else if (t >= BYTE_LIMIT)
               m_ff[i] <= M_MAX;
            else
               m_ff[i] <= t[M_W-1:0];
         end
      end
   end

   // divide by 10000 through the reciprocal
   always_ff @(posedge clock) begin
      if (cmd.recip) begin
         for (int i = 0; i < 3; i++) begin
            logic [M_W+RECIP_W-1:0] p;
            p = (M_W+RECIP_W)'(m_ff[i]) * (M_W+RECIP_W)'(RECIP_10K);
            q_ff[i] <= p[RECIP_SHIFT+7:RECIP_SHIFT];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         luma_ff <= q_ff[0];
         cv_ff   <= chroma_ff;
         u_ff    <= chroma_ff ? q_ff[1] : 8'd0;
         v_ff    <= chroma_ff ? q_ff[2] : 8'd0;
         fe_ff   <= frame_end_ff;
      end
   end

   assign rsp_luma         = luma_ff;
   assign rsp_chroma_valid = cv_ff;
   assign rsp_u_value      = u_ff;
   assign rsp_v_value      = v_ff;
   assign rsp_frame_end    = fe_ff;

endmodule

### test/rgb_to_yuv420_checker.sv
// Scoreboard for the RGB to 4:2:0 YCbCr converter: tracks register writes and
// accepted pixels, predicts each Y/U/V result and compares it with the output.
// Depends on ryuv_pkg for port widths and register indexes.
module rgb_to_yuv420_checker
   import ryuv_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_data,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  logic signed [15:0]   req_red,
   input  logic signed [15:0]   req_green,
   input  logic signed [15:0]   req_blue,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  logic [7:0]           rsp_luma,
   input  logic                 rsp_chroma_valid,
   input  logic [7:0]           rsp_u_value,
   input  logic [7:0]           rsp_v_value,
   input  logic                 rsp_frame_end,
   output int                   errors,
   output int                   pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint unsigned Q30 = 64'd1 << 30;
   localparam longint unsigned LUT_DEN = GAMMA_TABLE_SIZE - 1;
   localparam longint unsigned WORK_ONE = 64'd1 << WORK_BITS;

   typedef struct packed {
      logic [7:0] luma;
      logic       chroma_valid;
      logic [7:0] u_value;
      logic [7:0] v_value;
      logic       frame_end;
   } yuv_pixel_type;

   yuv_pixel_type    yuv_expected[$];
   longint unsigned  srgb_lut[GAMMA_TABLE_SIZE];
   int unsigned      line_r[LINE_DEPTH];
   int unsigned      line_g[LINE_DEPTH];
   int unsigned      line_b[LINE_DEPTH];
   int unsigned      held_r, held_g, held_b;
   int unsigned      col, row;
   int unsigned      cfg_width, cfg_height;
   logic             cfg_gamma;

   function automatic longint unsigned mul_q30(input longint unsigned a,
                                               input longint unsigned b);
      return (a * b) >> 30;
   endfunction

   function automatic longint unsigned cbrt_floor(input longint unsigned x);
      longint unsigned y;
      longint unsigned t;
      y = 0;
      for (int k = 30; k >= 0; k--) begin
         t = y | (64'd1 << k);
         if (t <= Q30 && mul_q30(mul_q30(t, t), t) <= x)
            y = t;
      end
      return y;
   endfunction

   function automatic longint unsigned sqrt_floor(input longint unsigned n);
      longint unsigned y;
      longint unsigned t;
      y = 0;
      for (int k = 30; k >= 0; k--) begin
         t = y | (64'd1 << k);
         if (t * t <= n)
            y = t;
      end
      return y;
   endfunction

   function automatic int unsigned clip_unit(input logic signed [15:0] v);
      if (v < 0)
         return 0;
      if (v > 16'sd4096)
         return 4096;
      return int'(v);
   endfunction

   // value in [0,1] at the given fraction bits, to Q18 through the curve if on
   function automatic longint unsigned encode_q18(input longint unsigned v, input int shift);
      longint unsigned idx;
      if (cfg_gamma) begin
         idx = (v * LUT_DEN + (64'd1 << (shift - 1))) >> shift;
         if (idx > LUT_DEN)
            idx = LUT_DEN;
         return srgb_lut[idx];
      end
      return v << (WORK_BITS - shift);
   endfunction

   function automatic logic [7:0] matrix_byte(input longint unsigned r, input longint unsigned g,
                                              input longint unsigned b, input longint kr,
                                              input longint kg, input longint kb,
                                              input longint scale, input longint add);
      longint den;
      longint num;
      longint q;
      den = 64'sd10000 * (64'sd1 << WORK_BITS);
      num = (kr * longint'(r) + kg * longint'(g) + kb * longint'(b)) * scale + add * den;
      if (num < 0)
         return 8'd0;
      q = num / den;
      return (q > 255) ? 8'd255 : q[7:0];
   endfunction

   initial begin
      longint unsigned q, x, t, t2, t5, s;
      for (longint unsigned i = 0; i < GAMMA_TABLE_SIZE; i++) begin
         if (i * 64'd10000000 <= 64'd31308 * LUT_DEN) begin
            q = (i * 64'd1292 * WORK_ONE + (64'd100 * LUT_DEN) / 2) / (64'd100 * LUT_DEN);
         end else begin
            x  = (i * Q30 + LUT_DEN / 2) / LUT_DEN;
            t  = sqrt_floor(sqrt_floor(cbrt_floor(x) << 30) << 30);
            t2 = mul_q30(t, t);
            t5 = mul_q30(mul_q30(t2, t2), t);
            s  = (t5 * 64'd1055 + 64'd500) / 64'd1000;
            s  = (s < 64'd59055800) ? 64'd0 : s - 64'd59055800;
            if (s > Q30)
               s = Q30;
            q = (s + 64'd2048) >> 12;
         end
         if (q > WORK_ONE)
            q = WORK_ONE;
         srgb_lut[i] = q;
      end
   end

   always @(posedge clock) begin
      yuv_pixel_type   e;
      yuv_pixel_type   got;
      int unsigned     pr, pg, pb, w, h, idx;
      longint unsigned sr, sg, sb, wr, wg, wb;
      logic            last_col, last_row;
      if (reset) begin
         yuv_expected.delete();
         for (int i = 0; i < LINE_DEPTH; i++) begin
            line_r[i] = 0;
            line_g[i] = 0;
            line_b[i] = 0;
         end
         held_r = 0;
         held_g = 0;
         held_b = 0;
         col = 0;
         row = 0;
         cfg_width = RESET_WIDTH;
         cfg_height = RESET_HEIGHT;
         cfg_gamma = 1'b0;
         errors = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_FRAME_WIDTH:  cfg_width = csr_data;
               CSR_FRAME_HEIGHT: cfg_height = csr_data;
               CSR_GAMMA_ENABLE: cfg_gamma = csr_data[0];
               default: ;
            endcase
         end

         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_luma, rsp_chroma_valid, rsp_u_value, rsp_v_value, rsp_frame_end};
            if (yuv_expected.size() == 0) begin
               if (errors < 10)
                  $display("%0t: result with no pixel pending: Y=%0d cv=%0d U=%0d V=%0d",
                           $realtime, got.luma, got.chroma_valid, got.u_value, got.v_value,
                           " fe=%0d", got.frame_end);
               errors++;
            end else begin
               e = yuv_expected.pop_front();
               if (got != e) begin
                  if (errors < 10)
                     $display("%0t: mismatch exp Y=%0d cv=%0d U=%0d V=%0d fe=%0d",
                              $realtime, e.luma, e.chroma_valid, e.u_value, e.v_value,
                              e.frame_end, " got Y=%0d cv=%0d U=%0d V=%0d fe=%0d",
                              got.luma, got.chroma_valid, got.u_value, got.v_value,
                              got.frame_end);
                  errors++;
               end
            end
         end

         if (req_valid && !req_stall) begin
            w = (cfg_width == 0) ? 1 : (cfg_width > MAX_WIDTH) ? MAX_WIDTH : cfg_width;
            h = (cfg_height == 0) ? 1 : (cfg_height > MAX_HEIGHT) ? MAX_HEIGHT : cfg_height;
            pr = clip_unit(req_red);
            pg = clip_unit(req_green);
            pb = clip_unit(req_blue);
            e.luma = matrix_byte(encode_q18(pr, FRACTION_BITS), encode_q18(pg, FRACTION_BITS),
                                 encode_q18(pb, FRACTION_BITS), 2126, 7152, 722, 219, 17);
            e.chroma_valid = 1'b0;
            e.u_value = 8'd0;
            e.v_value = 8'd0;
            if (col[0]) begin
               idx = col >> 1;
               if (idx < LINE_DEPTH) begin
                  if (!row[0]) begin
                     line_r[idx] = held_r + pr;
                     line_g[idx] = held_g + pg;
                     line_b[idx] = held_b + pb;
                  end else begin
                     // average of the 2x2 block, curve applied after the sum
                     sr = line_r[idx] + held_r + pr;
                     sg = line_g[idx] + held_g + pg;
                     sb = line_b[idx] + held_b + pb;
                     wr = encode_q18(sr, FRACTION_BITS + 2);
                     wg = encode_q18(sg, FRACTION_BITS + 2);
                     wb = encode_q18(sb, FRACTION_BITS + 2);
                     e.u_value = matrix_byte(wr, wg, wb, -1146, -3854, 5000, 224, 129);
                     e.v_value = matrix_byte(wr, wg, wb, 5000, -4542, -458, 224, 129);
                     e.chroma_valid = 1'b1;
                  end
               end
            end else begin
               held_r = pr;
               held_g = pg;
               held_b = pb;
            end
            last_col = (col + 1 >= w);
            last_row = (row + 1 >= h);
            e.frame_end = last_col && last_row;
            yuv_expected.push_back(e);
            if (last_col) begin
               col = 0;
               row = last_row ? 0 : row + 1;
            end else begin
               col++;
            end
         end
      end
      pending = yuv_expected.size();
   end

endmodule

### test/rgb_to_yuv420_converter_unit_test.sv
// Top of the converter testbench: clock, reset, register writes and pixel
// frames with random gaps and stalls; the verdict comes from rgb_to_yuv420_checker.
// Depends on ryuv_pkg, the converter RTL and the checker module.
module rgb_to_yuv420_converter_unit_test;
   import ryuv_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int HANG_LIMIT = 5000;
   localparam int PHASE_ITEMS = 270;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0]     csr_data = '0;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic signed [15:0]   req_red = '0;
   logic signed [15:0]   req_green = '0;
   logic signed [15:0]   req_blue = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [7:0]           rsp_luma;
   logic                 rsp_chroma_valid;
   logic [7:0]           rsp_u_value;
   logic [7:0]           rsp_v_value;
   logic                 rsp_frame_end;
   int                   errors;
   int                   pending;
   int                   gap_pct = 0;
   int                   stall_pct = 0;
   int                   pixels_sent = 0;
   int                   hang_count = 0;
   logic signed [15:0]   edge_vals[10] = '{-16'sd32768, 16'sd32767, 16'sd0, 16'sd4096,
                                          16'sd4097, -16'sd1, 16'sd4095, 16'sd12, 16'sd13,
                                          16'sd2048};

   rgb_to_yuv420_converter_unit uut (.*);
   rgb_to_yuv420_checker u_checker (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock)
      rsp_stall <= ($urandom_range(99) < stall_pct);

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready))
         hang_count <= 0;
      else if (hang_count >= HANG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else
         hang_count <= hang_count + 1;
   end

   function automatic int dim_of(input int v, input int max_v);
      return (v == 0) ? 1 : (v > max_v) ? max_v : v;
   endfunction

   function automatic logic signed [15:0] rand_comp();
      case ($urandom_range(7))
         0: return 16'($urandom);
         1: return 16'sd0;
         2: return 16'sd4096;
         3: return -$signed(16'($urandom_range(300)));
         4: return 16'sd4096 + 16'($urandom_range(300));
         default: return 16'($urandom_range(4096));
      endcase
   endfunction

   // leaves csr_valid high; the caller drops it after the last write
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val[CFG_W-1:0];
      do @(posedge clock); while (!csr_ready);
   endtask

   // leaves req_valid high so back-to-back requests need no extra edge
   task automatic push_pixel(input logic signed [15:0] r, input logic signed [15:0] g,
                             input logic signed [15:0] b);
      if ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_red <= r;
      req_green <= g;
      req_blue <= b;
      do @(posedge clock); while (req_stall);
      pixels_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic configure(input int w, input int h, input int gam);
      drain();
      write_reg(CSR_FRAME_WIDTH, w);
      write_reg(CSR_FRAME_HEIGHT, h);
      write_reg(CSR_GAMMA_ENABLE, gam);
      csr_valid <= 1'b0;
   endtask

   task automatic random_frame(input int w, input int h, input int gam);
      int n;
      configure(w, h, gam);
      n = dim_of(w, MAX_WIDTH) * dim_of(h, MAX_HEIGHT);
      repeat (n) push_pixel(rand_comp(), rand_comp(), rand_comp());
   endtask

   initial begin
      int w;
      int h;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // even frame, then odd last row and column with the curve on
      configure(4, 2, 0);
      for (int i = 0; i < 8; i++)
         push_pixel(edge_vals[i], edge_vals[(i + 3) % 10], edge_vals[(i + 7) % 10]);
      configure(3, 3, 1);
      write_reg(CSR_UNUSED, 13'h1fff);
      csr_valid <= 1'b0;
      for (int i = 0; i < 9; i++)
         push_pixel(edge_vals[(i + 1) % 10], edge_vals[(i + 5) % 10], edge_vals[9 - i]);
      // shrink the width in the middle of the first row
      configure(8, 2, 1);
      for (int i = 0; i < 3; i++)
         push_pixel(edge_vals[i + 2], edge_vals[i + 4], edge_vals[i]);
      drain();
      write_reg(CSR_FRAME_WIDTH, 4);
      csr_valid <= 1'b0;
      for (int i = 0; i < 5; i++)
         push_pixel(edge_vals[i + 3], edge_vals[i], edge_vals[i + 5]);

      for (int phase = 0; phase < 3; phase++) begin
         gap_pct = (phase == 0) ? 37 : (phase == 1) ? 80 : 0;
         stall_pct = (phase == 0) ? 80 : (phase == 1) ? 37 : 0;
         while (pixels_sent < 25 + PHASE_ITEMS * (phase + 1)) begin
            w = ($urandom_range(9) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 10);
            h = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 6);
            random_frame(w, h, $urandom_range(1));
         end
      end

      // out-of-range width, then cut the row short
      configure(8191, 2, $urandom_range(1));
      repeat (6) push_pixel(rand_comp(), rand_comp(), rand_comp());
      drain();
      write_reg(CSR_FRAME_WIDTH, 4);
      csr_valid <= 1'b0;
      repeat (4) push_pixel(rand_comp(), rand_comp(), rand_comp());
      // out-of-range height, then end the frame early
      configure(2, 8191, $urandom_range(1));
      repeat (4) push_pixel(rand_comp(), rand_comp(), rand_comp());
      drain();
      write_reg(CSR_FRAME_HEIGHT, 1);
      csr_valid <= 1'b0;
      repeat (2) push_pixel(rand_comp(), rand_comp(), rand_comp());

      drain();
      if (errors == 0 && pending == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
